>>> src/small_c_lexer_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the small C lexer
// Shared wrappers that give every concurrent check the same clock and reset.
// ----------------------------------------------------------------------------
`ifndef SMALL_C_LEXER_TOP_DEFINES_SVH
`define SMALL_C_LEXER_TOP_DEFINES_SVH

// Checks a property at every rising clock edge outside of reset.
`define SLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define SLC_NEVER(lbl, cond, msg) \
  `SLC_ASSERT(lbl, !(cond), msg)

`endif

>>> src/slc_pkg.sv
// ----------------------------------------------------------------------------
// Small C lexer package
// Types, token codes, keyword and operator tables, and character classes.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  localparam int TEXT_CHARS_DEF = 8;
  localparam int LINE_BITS_DEF  = 16;

  localparam int CH_W   = 8;
  localparam int KIND_W = 5;
  localparam int LINE_W = 16;
  localparam int LEN_W  = 8;
  localparam int TEXT_W = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;

  localparam logic [KIND_W-1:0] KIND_ID      = 5'd0;
  localparam logic [KIND_W-1:0] KIND_NUM     = 5'd1;
  localparam logic [KIND_W-1:0] KIND_KW0     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_OP0     = 5'd8;
  localparam logic [KIND_W-1:0] KIND_DIV     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_SEP0    = 5'd19;
  localparam logic [KIND_W-1:0] KIND_OCOMM   = 5'd25;
  localparam logic [KIND_W-1:0] KIND_CCOMM   = 5'd26;
  localparam logic [KIND_W-1:0] KIND_INVALID = 5'd27;

  localparam int NUM_KW = 6;
  localparam int NUM_OP = 11;

  // Keywords int, return, while, else, if, void; first character in the low byte.
  localparam logic [TEXT_W-1:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0074_6E69, 64'h0000_6E72_7574_6572, 64'h0000_0065_6C69_6877,
    64'h0000_0000_6573_6C65, 64'h0000_0000_0000_6669, 64'h0000_0000_6469_6F76
  };
  localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{8'd3, 8'd6, 8'd5, 8'd4, 8'd2, 8'd4};

  // Operators < > <= >= * + - / = |= ==.
  localparam logic [TEXT_W-1:0] OP_TEXT [NUM_OP] = '{
    64'h3C, 64'h3E, 64'h3D3C, 64'h3D3E, 64'h2A, 64'h2B,
    64'h2D, 64'h2F, 64'h3D, 64'h3D7C, 64'h3D3D
  };
  localparam logic [LEN_W-1:0] OP_LEN [NUM_OP] = '{
    8'd1, 8'd1, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2
  };

  typedef enum logic [1:0] {
    RUN_NONE,
    RUN_WORD,
    RUN_OPER,
    RUN_SEP
  } slc_run_e;

  typedef enum logic [1:0] {
    SRC_FIXED,
    SRC_WORD,
    SRC_OPER
  } slc_src_e;

  typedef struct packed {
    slc_src_e            src;
    logic [KIND_W-1:0]   kind;
    logic [LINE_W-1:0]   line;
    logic [LEN_W-1:0]    len;
    logic [TEXT_W-1:0]   text;
    logic                letters;
    logic                digits;
    logic                last;
  } slc_tok_t;

  typedef struct packed {
    logic [1:0] count;
    slc_tok_t   first;
    slc_tok_t   second;
  } slc_push_t;

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_opch(input logic [CH_W-1:0] c);
    return c == 8'h3C || c == 8'h3E || c == 8'h2A || c == 8'h2B ||
           c == 8'h2D || c == 8'h3D || c == 8'h7C;
  endfunction

  function automatic logic is_sep(input logic [CH_W-1:0] c);
    return c == 8'h7B || c == 8'h7D || c == 8'h28 || c == 8'h29 ||
           c == 8'h3B || c == 8'h2C;
  endfunction

  function automatic logic [KIND_W-1:0] sep_kind(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      8'h7B:   k = KIND_SEP0;
      8'h7D:   k = KIND_SEP0 + 5'd1;
      8'h28:   k = KIND_SEP0 + 5'd2;
      8'h29:   k = KIND_SEP0 + 5'd3;
      8'h3B:   k = KIND_SEP0 + 5'd4;
      8'h2C:   k = KIND_SEP0 + 5'd5;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> src/slc_front.sv
// ----------------------------------------------------------------------------
// Small C lexer front end
// Takes one character per transfer, tracks runs, comments and lines, and
// hands zero, one or two raw tokens per character to the token queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "small_c_lexer_top_defines.svh"

module slc_front
  import slc_pkg::*;
#(
  parameter int TEXT_CHARS = TEXT_CHARS_DEF,
  parameter int LINE_BITS  = LINE_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CH_W-1:0]  ch_i,
  input  wire logic             room_i,
  output slc_push_t             push_o
);

  logic                 in_comment_q, in_comment_d;
  logic                 slash_q, slash_d;
  logic                 star_q, star_d;
  slc_run_e             run_q, run_d;
  logic [TEXT_W-1:0]    text_q, text_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic                 letters_q, letters_d;
  logic                 digits_q, digits_d;
  logic [LINE_BITS-1:0] line_q, line_d;

  logic              accept;
  logic [31:0]       line_wide;
  logic [LINE_W-1:0] line16;
  slc_run_e          cls;
  logic              ch_sep;
  logic [TEXT_W-1:0] app_text;
  slc_tok_t          run_tok, tok_a, tok_b;
  logic              tok_a_v, tok_b_v;

  assign in_stall_o = !room_i;
  assign accept     = in_valid_i && room_i;
  assign line_wide  = 32'(line_q);
  assign line16     = line_wide[LINE_W-1:0];
  assign ch_sep     = is_sep(ch_i);

  function automatic slc_tok_t fixed_tok(input logic [KIND_W-1:0] kind,
                                         input logic [LEN_W-1:0] len,
                                         input logic [TEXT_W-1:0] text,
                                         input logic [LINE_W-1:0] line);
    slc_tok_t t;
    t.src     = SRC_FIXED;
    t.kind    = kind;
    t.line    = line;
    t.len     = len;
    t.text    = text;
    t.letters = 1'b0;
    t.digits  = 1'b0;
    t.last    = 1'b0;
    return t;
  endfunction

  always_comb begin
    if (is_opch(ch_i)) begin
      cls = RUN_OPER;
    end else if (ch_i == CH_SPACE || ch_sep) begin
      cls = RUN_NONE;
    end else begin
      cls = RUN_WORD;
    end
  end

  // Text after appending one character to the pending run.
  always_comb begin
    app_text = text_q;
    for (int i = 0; i < TEXT_CHARS; i++) begin
      if (len_q == LEN_W'(i)) begin
        app_text[8*i +: 8] = ch_i;
      end
    end
  end

  always_comb begin
    run_tok.src     = (run_q == RUN_SEP)  ? SRC_FIXED :
                      (run_q == RUN_OPER) ? SRC_OPER : SRC_WORD;
    run_tok.kind    = sep_kind(text_q[7:0]);
    run_tok.line    = line16;
    run_tok.len     = len_q;
    run_tok.text    = text_q;
    run_tok.letters = letters_q;
    run_tok.digits  = digits_q;
    run_tok.last    = 1'b0;
  end

  always_comb begin
    in_comment_d = in_comment_q;
    slash_d      = slash_q;
    star_d       = star_q;
    run_d        = run_q;
    text_d       = text_q;
    len_d        = len_q;
    letters_d    = letters_q;
    digits_d     = digits_q;
    line_d       = line_q;
    tok_a        = run_tok;
    tok_a_v      = 1'b0;
    tok_b        = fixed_tok(KIND_DIV, 8'd1, TEXT_W'(CH_SLASH), line16);
    tok_b_v      = 1'b0;

    if (accept) begin
      if (ch_i == CH_NL) begin
        if (!in_comment_q) begin
          tok_a_v   = run_q != RUN_NONE;
          tok_b_v   = slash_q;
          slash_d   = 1'b0;
          run_d     = RUN_NONE;
          text_d    = '0;
          len_d     = '0;
          letters_d = 1'b1;
          digits_d  = 1'b1;
        end
        if (line_q != {LINE_BITS{1'b1}}) begin
          line_d = line_q + LINE_BITS'(1);
        end
      end else if (in_comment_q) begin
        if (ch_i == CH_STAR) begin
          star_d = 1'b1;
        end else if (star_q && ch_i == CH_SLASH) begin
          in_comment_d = 1'b0;
          star_d       = 1'b0;
          tok_b        = fixed_tok(KIND_CCOMM, 8'd2, 64'h2F2A, line16);
          tok_b_v      = 1'b1;
        end else begin
          star_d = 1'b0;
        end
      end else if (slash_q) begin
        run_d     = RUN_NONE;
        text_d    = '0;
        len_d     = '0;
        letters_d = 1'b1;
        digits_d  = 1'b1;
        if (ch_i == CH_STAR) begin
          slash_d      = 1'b0;
          in_comment_d = 1'b1;
          star_d       = 1'b0;
          tok_b        = fixed_tok(KIND_OCOMM, 8'd2, 64'h2A2F, line16);
          tok_b_v      = 1'b1;
        end else begin
          tok_a_v = run_q != RUN_NONE;
          tok_b_v = 1'b1;
          slash_d = ch_i == CH_SLASH;
          // A character after the slash other than a space or a slash starts a
          // fresh run; a separator is held so that this character gives at most two tokens.
          if (ch_i != CH_SLASH && (ch_sep || cls != RUN_NONE)) begin
            run_d     = ch_sep ? RUN_SEP : cls;
            text_d    = TEXT_W'(ch_i);
            len_d     = 8'd1;
            letters_d = is_letter(ch_i);
            digits_d  = is_digit(ch_i);
          end
        end
      end else if (ch_i == CH_SLASH) begin
        if (run_q == RUN_SEP) begin
          tok_a_v   = 1'b1;
          run_d     = RUN_NONE;
          text_d    = '0;
          len_d     = '0;
          letters_d = 1'b1;
          digits_d  = 1'b1;
        end
        slash_d = 1'b1;
      end else if (cls != RUN_NONE && cls == run_q) begin
        text_d    = app_text;
        len_d     = (len_q == {LEN_W{1'b1}}) ? len_q : len_q + 8'd1;
        letters_d = letters_q && is_letter(ch_i);
        digits_d  = digits_q && is_digit(ch_i);
      end else begin
        tok_a_v   = run_q != RUN_NONE;
        run_d     = cls;
        text_d    = (cls != RUN_NONE) ? TEXT_W'(ch_i) : '0;
        len_d     = (cls != RUN_NONE) ? 8'd1 : 8'd0;
        letters_d = (cls != RUN_NONE) ? is_letter(ch_i) : 1'b1;
        digits_d  = (cls != RUN_NONE) ? is_digit(ch_i) : 1'b1;
        if (ch_sep) begin
          tok_b   = fixed_tok(sep_kind(ch_i), 8'd1, TEXT_W'(ch_i), line16);
          tok_b_v = 1'b1;
        end
      end
    end
  end

  // Compact the two candidate tokens and mark the final one.
  always_comb begin
    push_o.count       = 2'(tok_a_v) + 2'(tok_b_v);
    push_o.first       = tok_a_v ? tok_a : tok_b;
    push_o.first.last  = !(tok_a_v && tok_b_v);
    push_o.second      = tok_b;
    push_o.second.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_comment_q <= 1'b0;
      slash_q      <= 1'b0;
      star_q       <= 1'b0;
      run_q        <= RUN_NONE;
      text_q       <= '0;
      len_q        <= '0;
      letters_q    <= 1'b1;
      digits_q     <= 1'b1;
      line_q       <= LINE_BITS'(1);
    end else begin
      in_comment_q <= in_comment_d;
      slash_q      <= slash_d;
      star_q       <= star_d;
      run_q        <= run_d;
      text_q       <= text_d;
      len_q        <= len_d;
      letters_q    <= letters_d;
      digits_q     <= digits_d;
      line_q       <= line_d;
    end
  end

  `SLC_NEVER(a_comment_slash, in_comment_q && slash_q, "slash held inside a comment")
  `SLC_NEVER(a_sep_slash, (run_q == RUN_SEP) && slash_q, "held separator with held slash")
  `SLC_ASSERT(a_comment_norun, in_comment_q |-> (run_q == RUN_NONE), "run open in comment")

endmodule

`default_nettype wire

>>> src/slc_queue.sv
// ----------------------------------------------------------------------------
// Small C lexer token queue
// Short queue that takes up to two tokens per cycle while it has room and releases at most one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "small_c_lexer_top_defines.svh"

module slc_queue
  import slc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire slc_push_t  push_i,
  output logic            room_o,
  input  wire logic       pop_i,
  output logic            avail_o,
  output slc_tok_t        head_o
);

  slc_tok_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic [QPTR_W-1:0]   wr_next;

  assign wr_next = wr_ptr_q + QPTR_W'(1);
  assign room_o  = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
  assign avail_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_i.count);
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i.count) - QCNT_W'(pop_i);
    end
  end

  `SLC_ASSERT(a_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
  `SLC_ASSERT(a_push_room, (push_i.count != 2'd0) |-> room_o, "push without room")

endmodule

`default_nettype wire

>>> src/slc_back.sv
// ----------------------------------------------------------------------------
// Small C lexer back end
// Classifies word and operator runs and holds the token in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_back
  import slc_pkg::*;
#(
  parameter int TEXT_CHARS = TEXT_CHARS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire slc_tok_t           head_i,
  input  wire logic               avail_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [KIND_W-1:0]       token_kind_o,
  output logic [LINE_W-1:0]       line_number_o,
  output logic [LEN_W-1:0]        token_length_o,
  output logic [TEXT_W-1:0]       token_text_o,
  output logic                    truncated_o,
  output logic                    last_o
);

  logic              valid_q;
  logic [KIND_W-1:0] kind;

  assign pop_o       = avail_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;

  always_comb begin
    case (head_i.src)
      SRC_FIXED: kind = head_i.kind;
      SRC_OPER: begin
        kind = KIND_INVALID;
        for (int i = 0; i < NUM_OP; i++) begin
          if (head_i.len == OP_LEN[i] && head_i.text == OP_TEXT[i]) begin
            kind = KIND_OP0 + KIND_W'(i);
          end
        end
      end
      SRC_WORD: begin
        kind = head_i.digits ? KIND_NUM : head_i.letters ? KIND_ID : KIND_INVALID;
        for (int i = 0; i < NUM_KW; i++) begin
          if (head_i.len == KW_LEN[i] && head_i.text == KW_TEXT[i]) begin
            kind = KIND_KW0 + KIND_W'(i);
          end
        end
      end
      default: kind = KIND_INVALID;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      token_kind_o   <= kind;
      line_number_o  <= head_i.line;
      token_length_o <= head_i.len;
      token_text_o   <= head_i.text;
      truncated_o    <= head_i.len > LEN_W'(TEXT_CHARS);
      last_o         <= head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/small_c_lexer_top.sv
// ----------------------------------------------------------------------------
// Small C lexer top level
// Character-serial scanner that turns source text into tokens of a C subset.
// ----------------------------------------------------------------------------
// The lexer takes one character per transfer on the input channel and
// returns tokens on the output channel, each with its kind, line number,
// length, first characters and a truncation flag; "last" marks the final
// token that a character causes. A character may cause no token, one or two.
// The front end takes one character every cycle as long as the token queue
// between front and back holds at most two tokens, so the input is stalled
// when that queue fills: a stalled output side or characters that each
// cause two tokens can fill it. The back end classifies and sends one token
// per cycle while the output is not stalled; a completed token passes the
// queue write, then the output register. Reset clears the control state at
// once; the queue storage and output data are not reset, and there is no
// clearing pass.
`default_nettype none

module small_c_lexer_top
  import slc_pkg::*;
#(
  parameter int TEXT_CHARS = TEXT_CHARS_DEF,
  parameter int LINE_BITS  = LINE_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CH_W-1:0]    ch_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [KIND_W-1:0]       token_kind_o,
  output logic [LINE_W-1:0]       line_number_o,
  output logic [LEN_W-1:0]        token_length_o,
  output logic [TEXT_W-1:0]       token_text_o,
  output logic                    truncated_o,
  output logic                    last_o
);

  slc_push_t push;
  slc_tok_t  head;
  logic      room;
  logic      avail;
  logic      pop;

  // Front end: run tracking, comment and slash handling, line counting.
  slc_front #(
    .TEXT_CHARS (TEXT_CHARS),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .room_i     (room),
    .push_o     (push)
  );

  // Queue that holds the tokens and absorbs the second token of a character.
  slc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .pop_i   (pop),
    .avail_o (avail),
    .head_o  (head)
  );

  // Back end: keyword and operator matching and the output register.
  slc_back #(
    .TEXT_CHARS (TEXT_CHARS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .avail_i        (avail),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .line_number_o  (line_number_o),
    .token_length_o (token_length_o),
    .token_text_o   (token_text_o),
    .truncated_o    (truncated_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire
